@@ src/dqrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dqrs_pkg: deque with running statistics, shared types and constants
// Command codes, status codes, sizes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package dqrs_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 40;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QDEPTH     = 2;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_CONTAINS   = 3'd5,
        CMD_COUNT_EQ   = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [DATA_W-1:0]  value;
    } word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDPOP,
        S_SCAN,
        S_SCANLAST,
        S_ENDS,
        S_ENDS2,
        S_REPORT
    } state_t;

endpackage

@@ src/deque_with_running_stats.sv @@
// ----------------------------------------------------------------------------
// deque_with_running_stats: bounded deque with count, sum, max and min
// Command queue in front, ring-store engine behind.
// ----------------------------------------------------------------------------
//  channel   handshake                     word
//  command   start & !busy                 cmd, value
//  result    done (one cycle, no stall)    status .. match_total
//
//  Push/clear/nop: ENDS, ENDS2, REPORT; pop adds RDPOP; empty pop: REPORT only.
//  Contains, count, and pops that remove an extreme walk the store,
//  one entry per cycle on the single read port.
//  Two commands queue ahead of the engine; busy rises when both are full.
//  Reset clears count, sum, extremes and front index; the store is not cleared.
module deque_with_running_stats
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic [8:0]         elem_count,
    output logic signed [39:0] total,
    output logic signed [31:0] largest,
    output logic signed [31:0] smallest,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic               found,
    output logic [8:0]         match_total
);
    import dqrs_pkg::*;

    logic  q_valid, q_take;
    word_t q_word;

    dqrs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .value   (value),
        .busy    (busy),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take)
    );

    dqrs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_take      (q_take),
        .done        (done),
        .status      (status),
        .elem_count  (elem_count),
        .total       (total),
        .largest     (largest),
        .smallest    (smallest),
        .front_value (front_value),
        .back_value  (back_value),
        .found       (found),
        .match_total (match_total)
    );

endmodule

@@ src/dqrs_front.sv @@
// ----------------------------------------------------------------------------
// dqrs_front: command intake
// Two-entry queue of command words feeding the execution engine.
// ----------------------------------------------------------------------------
module dqrs_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2:0]                cmd,
    input  logic signed [31:0]        value,
    output logic                      busy,
    output logic                      q_valid,
    output dqrs_pkg::word_t           q_word,
    input  logic                      q_take
);
    import dqrs_pkg::*;

    word_t       mem_reg [QDEPTH];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;

    assign busy    = (cnt_reg == 2'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = (q_take && q_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_take && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{cmd: cmd_t'(cmd), value: value};
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue overflow");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("take from empty queue");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH)) |-> busy) else $error("busy missing");
`endif

endmodule

@@ src/dqrs_back.sv @@
// ----------------------------------------------------------------------------
// dqrs_back: execution engine
// Ring store, count, sum and extremes; walks the store for searches and
// extreme recomputation, one entry per cycle.
// ----------------------------------------------------------------------------
module dqrs_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  dqrs_pkg::word_t           q_word,
    output logic                      q_take,
    output logic                      done,
    output logic [1:0]                status,
    output logic [8:0]                elem_count,
    output logic signed [39:0]        total,
    output logic signed [31:0]        largest,
    output logic signed [31:0]        smallest,
    output logic signed [31:0]        front_value,
    output logic signed [31:0]        back_value,
    output logic                      found,
    output logic [8:0]                match_total
);
    import dqrs_pkg::*;

    logic signed [DATA_W-1:0] ram [DEPTH];

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         front_reg, front_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] max_reg, max_next, min_reg, min_next;
    cmd_t                     cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [1:0]               st_reg, st_next;
    logic                     fmax_reg, fmax_next, fmin_reg, fmin_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         hits_reg, hits_next;
    logic signed [DATA_W-1:0] fv_reg, fv_next, bv_reg, bv_next;

    logic                     we;
    logic [IDX_W-1:0]         waddr, raddr;
    logic signed [DATA_W-1:0] wdata, rdata;
    logic                     rd_ok;

    logic [IDX_W-1:0] back_idx;
    assign back_idx = front_reg + IDX_W'(count_reg) - IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        rdata <= ram[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_word.cmd)
                        CMD_POP_FRONT, CMD_POP_BACK:
                            state_next = (count_reg == '0) ? S_REPORT : S_RDPOP;
                        CMD_CONTAINS, CMD_COUNT_EQ:
                            state_next = (count_reg == '0) ? S_ENDS : S_SCAN;
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                            state_next = S_ENDS;
                        default:
                            state_next = S_ENDS;
                    endcase
                end
            end
            S_RDPOP:
                state_next = (fmax_next || fmin_next) && (count_reg != CNT_W'(1)) ?
                             S_SCAN : S_ENDS;
            S_SCAN:
                state_next = (pos_reg == count_reg - CNT_W'(1)) ? S_SCANLAST : S_SCAN;
            S_SCANLAST:
                state_next = S_ENDS;
            S_ENDS:
                state_next = S_ENDS2;
            S_ENDS2:
                state_next = S_REPORT;
            S_REPORT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        fmax_next  = fmax_reg;
        fmin_next  = fmin_reg;
        pos_next   = pos_reg;
        hits_next  = hits_reg;
        fv_next    = fv_reg;
        bv_next    = bv_reg;
        q_take     = 1'b0;
        we         = 1'b0;
        waddr      = front_reg;
        wdata      = q_word.value;
        raddr      = front_reg;
        rd_ok      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take    = 1'b1;
                    cmd_next  = q_word.cmd;
                    val_next  = q_word.value;
                    st_next   = ST_DONE;
                    pos_next  = '0;
                    hits_next = '0;
                    fmax_next = 1'b0;
                    fmin_next = 1'b0;
                    unique case (q_word.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we = 1'b1;
                                if (q_word.cmd == CMD_PUSH_FRONT)
                                begin
                                    front_next = front_reg - IDX_W'(1);
                                    waddr      = front_reg - IDX_W'(1);
                                end
                                else
                                begin
                                    waddr = front_reg + IDX_W'(count_reg);
                                end
                                count_next = count_reg + CNT_W'(1);
                                sum_next   = sum_reg + SUM_W'(q_word.value);
                                if (q_word.value > max_reg) max_next = q_word.value;
                                if (q_word.value < min_reg) min_next = q_word.value;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            raddr = (q_word.cmd == CMD_POP_FRONT) ? front_reg : back_idx;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            max_next   = MOST_NEG;
                            min_next   = MOST_POS;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RDPOP:
            begin
                fmax_next  = (rdata == max_reg);
                fmin_next  = (rdata == min_reg);
                sum_next   = sum_reg - SUM_W'(rdata);
                count_next = count_reg - CNT_W'(1);
                if (cmd_reg == CMD_POP_FRONT)
                    front_next = front_reg + IDX_W'(1);
                if (fmax_next) max_next = MOST_NEG;
                if (fmin_next) min_next = MOST_POS;
                raddr = (cmd_reg == CMD_POP_FRONT) ? front_reg + IDX_W'(1) : front_reg;
            end
            S_SCAN, S_SCANLAST:
            begin
                rd_ok = (state_reg == S_SCANLAST) || (pos_reg != '0);
                if (state_reg == S_SCAN)
                begin
                    raddr    = front_reg + IDX_W'(pos_reg) +
                               ((pos_reg == '0) ? IDX_W'(0) : IDX_W'(1));
                    pos_next = pos_reg + CNT_W'(1);
                end
                if (rd_ok || (state_reg == S_SCAN && pos_reg == '0 && 1'b0))
                begin
                    if (rdata == val_reg) hits_next = hits_reg + CNT_W'(1);
                    if (fmax_reg && rdata > max_reg) max_next = rdata;
                    if (fmin_reg && rdata < min_reg) min_next = rdata;
                end
                raddr = front_reg + IDX_W'(pos_reg);
            end
            S_ENDS:
            begin
                raddr = front_reg;
            end
            S_ENDS2:
            begin
                raddr   = back_idx;
                fv_next = rdata;
            end
            S_REPORT:
            begin
                bv_next = rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= MOST_NEG;
            min_reg   <= MOST_POS;
            pos_reg   <= '0;
            hits_reg  <= '0;
            fmax_reg  <= 1'b0;
            fmin_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            pos_reg   <= pos_next;
            hits_reg  <= hits_next;
            fmax_reg  <= fmax_next;
            fmin_reg  <= fmin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        fv_reg  <= fv_next;
        bv_reg  <= bv_next;
    end

    // outputs, registered
    logic        done_reg;
    logic [1:0]  o_st_reg;
    logic [8:0]  o_cnt_reg, o_hit_reg;
    logic signed [39:0] o_sum_reg;
    logic signed [31:0] o_max_reg, o_min_reg, o_fv_reg, o_bv_reg;
    logic        o_fnd_reg;
    logic        empty_now;

    assign empty_now = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_REPORT);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT)
        begin
            o_st_reg  <= st_reg;
            o_cnt_reg <= count_reg;
            o_sum_reg <= sum_reg;
            o_max_reg <= max_reg;
            o_min_reg <= min_reg;
            o_fv_reg  <= empty_now ? '0 : fv_reg;
            o_bv_reg  <= empty_now ? '0 : bv_next;
            o_fnd_reg <= (cmd_reg == CMD_CONTAINS) && (hits_reg != '0);
            o_hit_reg <= (cmd_reg == CMD_COUNT_EQ) ? hits_reg : '0;
        end
    end

    assign done        = done_reg;
    assign status      = o_st_reg;
    assign elem_count  = o_cnt_reg;
    assign total       = o_sum_reg;
    assign largest     = o_max_reg;
    assign smallest    = o_min_reg;
    assign front_value = o_fv_reg;
    assign back_value  = o_bv_reg;
    assign found       = o_fnd_reg;
    assign match_total = o_hit_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("count out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (state_reg == S_IDLE)) else $error("take outside idle");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("double report");
    a_empty_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT && empty_now) |-> (max_reg == MOST_NEG && min_reg == MOST_POS))
        else $error("extremes not reset when empty");
`endif

endmodule

@@ tb/deque_with_running_stats_tb.sv @@
// ----------------------------------------------------------------------------
// deque_with_running_stats_tb: self-checking bench for the statistics deque
// Directed table, fill/empty run, random push/pop/search traffic; every word
// is checked against a behavioral deque model with count, sum, max and min.
// ----------------------------------------------------------------------------
module deque_with_running_stats_tb;
    import dqrs_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         elem_count;
        logic signed [39:0] total;
        logic signed [31:0] largest;
        logic signed [31:0] smallest;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               found;
        logic [8:0]         match_total;
    } report_t;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] value;
        bit                 chk;
        status_t            status;
        int                 cnt;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic [8:0]         elem_count;
    logic signed [39:0] total;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               found;
    logic [8:0]         match_total;

    logic signed [31:0] mdl_store[DEPTH];
    logic [7:0]         mdl_front;
    int                 mdl_count;
    logic signed [39:0] mdl_sum;
    logic signed [31:0] mdl_max;
    logic signed [31:0] mdl_min;

    report_t            expected_reports[$];
    int                 errors;
    int                 idle_pct;
    logic signed [31:0] recent[8];

    deque_with_running_stats i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .done        (done),
        .status      (status),
        .elem_count  (elem_count),
        .total       (total),
        .largest     (largest),
        .smallest    (smallest),
        .front_value (front_value),
        .back_value  (back_value),
        .found       (found),
        .match_total (match_total)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [31:0] at_pos(int pos);
        return mdl_store[8'(mdl_front + pos)];
    endfunction

    function automatic void rescan_extremes(bit do_max, bit do_min);
        if (do_max)
        begin
            mdl_max = MOST_NEG;
            for (int i = 0; i < mdl_count; i++)
                if (at_pos(i) > mdl_max) mdl_max = at_pos(i);
        end
        if (do_min)
        begin
            mdl_min = MOST_POS;
            for (int i = 0; i < mdl_count; i++)
                if (at_pos(i) < mdl_min) mdl_min = at_pos(i);
        end
    endfunction

    function automatic report_t apply_command(cmd_t c, logic signed [31:0] d);
        report_t            r;
        logic signed [31:0] gone;
        int                 hits;
        r = '0;
        hits = 0;
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (mdl_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (c == CMD_PUSH_FRONT)
                    begin
                        mdl_front = mdl_front - 8'd1;
                        mdl_store[mdl_front] = d;
                    end
                    else
                        mdl_store[8'(mdl_front + mdl_count)] = d;
                    mdl_count++;
                    mdl_sum = mdl_sum + 40'(d);
                    if (d > mdl_max) mdl_max = d;
                    if (d < mdl_min) mdl_min = d;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (mdl_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (c == CMD_POP_FRONT)
                    begin
                        gone = mdl_store[mdl_front];
                        mdl_front = mdl_front + 8'd1;
                    end
                    else
                        gone = at_pos(mdl_count - 1);
                    mdl_count--;
                    mdl_sum = mdl_sum - 40'(gone);
                    rescan_extremes(gone == mdl_max, gone == mdl_min);
                end
            end
            CMD_CLEAR:
            begin
                mdl_count = 0;
                mdl_sum = '0;
                mdl_max = MOST_NEG;
                mdl_min = MOST_POS;
            end
            CMD_CONTAINS, CMD_COUNT_EQ:
            begin
                for (int i = 0; i < mdl_count; i++)
                    if (at_pos(i) == d) hits++;
                if (c == CMD_CONTAINS)
                    r.found = (hits != 0);
                else
                    r.match_total = 9'(hits);
            end
            default:
            begin
            end
        endcase
        r.elem_count = 9'(mdl_count);
        r.total = mdl_sum;
        r.largest = mdl_max;
        r.smallest = mdl_min;
        r.front_value = mdl_count ? mdl_store[mdl_front] : '0;
        r.back_value = mdl_count ? at_pos(mdl_count - 1) : '0;
        return r;
    endfunction

    // drive one word; sender idles at random first
    task automatic send_word(cmd_t c, logic signed [31:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        value <= d;
        expected_reports.push_back(apply_command(c, d));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        report_t got;
        report_t exp;
        if (rst_n && done)
        begin
            got = '{status, elem_count, total, largest, smallest, front_value,
                    back_value, found, match_total};
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                exp = expected_reports.pop_front();
                if (got !== exp)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch\n  exp %p\n  got %p", exp, got);
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2, 3, 4: return recent[$urandom_range(7)];
            5, 6: return 32'(int'($urandom_range(20)) - 10) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        cmd_t               c;
        logic signed [31:0] d;
        int                 k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 28)      c = CMD_PUSH_BACK;
            else if (k < 50) c = CMD_PUSH_FRONT;
            else if (k < 66) c = CMD_POP_FRONT;
            else if (k < 80) c = CMD_POP_BACK;
            else if (k < 88) c = CMD_CONTAINS;
            else if (k < 96) c = CMD_COUNT_EQ;
            else if (k < 98) c = CMD_NOP;
            else             c = CMD_CLEAR;
            d = pick_value();
            recent[$urandom_range(7)] = d;
            send_word(c, d);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    row_t directed[] = '{
        '{CMD_POP_FRONT,  32'sd0,       1'b1, ST_EMPTY, 0},
        '{CMD_POP_BACK,   32'sd0,       1'b1, ST_EMPTY, 0},
        '{CMD_NOP,        32'sd5,       1'b1, ST_DONE,  0},
        '{CMD_PUSH_BACK,  MOST_POS,     1'b1, ST_DONE,  1},
        '{CMD_PUSH_FRONT, MOST_NEG,     1'b1, ST_DONE,  2},
        '{CMD_PUSH_BACK,  32'sh0001_8000, 1'b0, ST_DONE, 0},
        '{CMD_PUSH_FRONT, -32'sh0002_0000, 1'b0, ST_DONE, 0},
        '{CMD_CONTAINS,   MOST_POS,     1'b0, ST_DONE,  0},
        '{CMD_CONTAINS,   32'sd7,       1'b0, ST_DONE,  0},
        '{CMD_PUSH_BACK,  MOST_POS,     1'b0, ST_DONE,  0},
        '{CMD_COUNT_EQ,   MOST_POS,     1'b0, ST_DONE,  0},
        '{CMD_POP_BACK,   32'sd0,       1'b0, ST_DONE,  0},
        '{CMD_POP_FRONT,  32'sd0,       1'b0, ST_DONE,  0},
        '{CMD_POP_BACK,   32'sd0,       1'b0, ST_DONE,  0},
        '{CMD_POP_FRONT,  32'sd0,       1'b0, ST_DONE,  0},
        '{CMD_PUSH_BACK,  32'sh5555_AAAA, 1'b0, ST_DONE, 0},
        '{CMD_CLEAR,      32'sd0,       1'b1, ST_DONE,  0},
        '{CMD_POP_BACK,   32'sd0,       1'b1, ST_EMPTY, 0}
    };

    initial
    begin
        report_t r;
        errors = 0;
        idle_pct = 30;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = CMD_NOP;
        value = '0;
        mdl_front = '0;
        mdl_count = 0;
        mdl_sum   = '0;
        mdl_max   = MOST_NEG;
        mdl_min   = MOST_POS;
        foreach (recent[i]) recent[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_word(directed[i].cmd, directed[i].value);
            r = expected_reports[$];
            if (directed[i].chk &&
                (r.status != directed[i].status || r.elem_count != directed[i].cnt))
            begin
                errors++;
                if (errors <= 10)
                    $display("table row %0d: model disagrees with table", i);
            end
        end

        // fill to full, refuse, then empty past zero
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
        send_word(CMD_COUNT_EQ, recent[0]);
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(i[0] ? CMD_POP_FRONT : CMD_POP_BACK, '0);
        drain();

        random_phase(105);
        drain();
        idle_pct = 49;
        random_phase(105);
        drain();
        idle_pct = 0;
        random_phase(105);
        drain();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
